// File: rtl/psrr_pkg.sv
// Shared constants, types and a saturating-add helper for the repulsion unit.
`default_nettype none
package psrr_pkg;
    localparam int MAX_P  = 64;
    localparam int IDX_W  = $clog2(MAX_P);
    localparam int CNT_W  = IDX_W + 1;
    localparam logic [31:0] GAIN_RST = 32'd33;

    localparam logic [1:0] WSEL_LOAD = 2'd0;
    localparam logic [1:0] WSEL_A    = 2'd1;
    localparam logic [1:0] WSEL_B    = 2'd2;

    typedef struct packed {
        logic             wr_en;
        logic [1:0]       wr_sel;
        logic [IDX_W-1:0] wr_addr;
        logic [IDX_W-1:0] rd_a;
        logic [IDX_W-1:0] rd_b;
        logic             chk;
        logic             sq;
        logic             sum;
        logic             mul;
        logic             dinit;
        logic             dstep;
        logic             upd;
        logic [1:0]       k;
        logic             out_load;
        logic [IDX_W-1:0] out_idx;
        logic             out_last;
    } t_cmd;

    typedef struct packed {
        logic skip;
    } t_sts;

    // Saturating add of a 34-bit signed force to a 32-bit velocity; msb is the clip flag.
    function automatic logic [32:0] sat_add(input logic signed [31:0] v,
                                            input logic signed [33:0] f);
        logic signed [34:0] s;
        s = 35'(v) + 35'(f);
        if (s > 35'sh0_7FFF_FFFF)
            return {1'b1, 32'h7FFF_FFFF};
        else if (s < -35'sh0_8000_0000)
            return {1'b1, 32'h8000_0000};
        else
            return {1'b0, s[31:0]};
    endfunction
endpackage
`default_nettype wire

// File: rtl/pairwise_short_range_repulsion_unit.sv
// Top level of the pairwise short-range repulsion unit.
// Particles load at one per cycle until one is marked last or the set holds MAX_P; the input
// then stalls while every pair is visited and the results go out. A pair that is out of range
// or coincident is skipped; a pair that acts runs the one-bit-a-cycle divider once for each
// of the three components. Each result is then read out and held until the receiver takes it.
`default_nettype none
module pairwise_short_range_repulsion_unit import psrr_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire        [31:0] i_cfg_wdata,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire        [31:0] i_pos_x,
    input  wire        [31:0] i_pos_y,
    input  wire        [31:0] i_pos_z,
    input  wire        [31:0] i_in_vel_x,
    input  wire        [31:0] i_in_vel_y,
    input  wire        [31:0] i_in_vel_z,
    input  wire               i_last_particle,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic [IDX_W-1:0]  o_particle_index,
    output logic       [31:0] o_out_vel_x,
    output logic       [31:0] o_out_vel_y,
    output logic       [31:0] o_out_vel_z,
    output logic              o_clipped,
    output logic              o_last_result
);
    t_cmd w_cmd;
    t_sts w_sts;

    psrr_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_last_particle (i_last_particle),
        .o_in_stall      (o_in_stall),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    psrr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_ld_pos         ({i_pos_z, i_pos_y, i_pos_x}),
        .i_ld_vel         ({i_in_vel_z, i_in_vel_y, i_in_vel_x}),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .o_particle_index (o_particle_index),
        .o_out_vel_x      (o_out_vel_x),
        .o_out_vel_y      (o_out_vel_y),
        .o_out_vel_z      (o_out_vel_z),
        .o_clipped        (o_clipped),
        .o_last_result    (o_last_result)
    );
endmodule
`default_nettype wire

// File: rtl/psrr_dp.sv
// Datapath: particle memories, distance check, squares, divider and velocity update.
`default_nettype none
module psrr_dp import psrr_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire        [31:0] i_cfg_wdata,
    input  wire        [95:0] i_ld_pos,
    input  wire        [95:0] i_ld_vel,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic [IDX_W-1:0]  o_particle_index,
    output logic       [31:0] o_out_vel_x,
    output logic       [31:0] o_out_vel_y,
    output logic       [31:0] o_out_vel_z,
    output logic              o_clipped,
    output logic              o_last_result
);
    logic [95:0] mem_pos [MAX_P];
    logic [96:0] mem_vel [MAX_P];

    logic [31:0] r_gain;
    logic [95:0] r_rdpa, r_rdpb;
    logic [96:0] r_rdva, r_rdvb;
    logic [31:0] r_va [3];
    logic [31:0] r_vb [3];
    logic        r_ca, r_cb;
    logic [15:0] r_mag [3];
    logic        r_neg [3];
    logic        r_far;
    logic [31:0] r_sq [3];
    logic [33:0] r_s;
    logic [47:0] r_num;
    logic [31:0] r_rem, r_dvd, r_q;
    logic        r_qsat;

    logic [96:0] n_wdata;
    logic [32:0] n_rem2;
    logic [32:0] n_qv;
    logic signed [33:0] n_f;
    logic [32:0] n_ua, n_ub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= GAIN_RST;
        end else if (i_cfg_we) begin
            r_gain <= i_cfg_wdata;
        end
    end

    always_comb begin
        case (i_cmd.wr_sel)
            WSEL_A:  n_wdata = {r_ca, r_va[2], r_va[1], r_va[0]};
            WSEL_B:  n_wdata = {r_cb, r_vb[2], r_vb[1], r_vb[0]};
            default: n_wdata = {1'b0, i_ld_vel};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem_vel[i_cmd.wr_addr] <= n_wdata;
            if (i_cmd.wr_sel == WSEL_LOAD)
                mem_pos[i_cmd.wr_addr] <= i_ld_pos;
        end
        r_rdpa <= mem_pos[i_cmd.rd_a];
        r_rdpb <= mem_pos[i_cmd.rd_b];
        r_rdva <= mem_vel[i_cmd.rd_a];
        r_rdvb <= mem_vel[i_cmd.rd_b];
    end

    assign n_rem2 = {r_rem, r_dvd[31]};
    assign n_qv   = r_qsat ? 33'h1_0000_0000 : {1'b0, r_q};
    assign n_f    = r_neg[i_cmd.k] ? -34'(n_qv) : 34'(n_qv);
    assign n_ua   = sat_add(r_va[i_cmd.k], n_f);
    assign n_ub   = sat_add(r_vb[i_cmd.k], -n_f);

    always_ff @(posedge i_clk) begin
        logic signed [32:0] d;
        if (i_cmd.chk) begin
            r_far <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                d = 33'(signed'(r_rdpa[32*k +: 32])) - 33'(signed'(r_rdpb[32*k +: 32]));
                r_neg[k] <= d[32];
                r_mag[k] <= d[32] ? 16'(-d) : d[15:0];
                if (d >= 33'sd65536 || d <= -33'sd65536)
                    r_far <= 1'b1;
                r_va[k] <= r_rdva[32*k +: 32];
                r_vb[k] <= r_rdvb[32*k +: 32];
            end
            r_ca <= r_rdva[96];
            r_cb <= r_rdvb[96];
        end
        if (i_cmd.sq) begin
            for (int k = 0; k < 3; k++)
                r_sq[k] <= 32'(r_mag[k] * r_mag[k]);
        end
        if (i_cmd.sum)
            r_s <= 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]);
        if (i_cmd.mul)
            r_num <= 48'(r_gain) * 48'(r_mag[i_cmd.k]);
        if (i_cmd.dinit) begin
            // quotient of 2^32 or more clamps, so only the low 32 bits need a divide
            r_qsat <= (r_num[47:16] >= r_s[31:0]);
            r_rem  <= r_num[47:16];
            r_dvd  <= {r_num[15:0], 16'h0000};
            r_q    <= '0;
        end
        if (i_cmd.dstep) begin
            r_dvd <= {r_dvd[30:0], 1'b0};
            if (n_rem2 >= {1'b0, r_s[31:0]}) begin
                r_rem <= 32'(n_rem2 - {1'b0, r_s[31:0]});
                r_q   <= {r_q[30:0], 1'b1};
            end else begin
                r_rem <= n_rem2[31:0];
                r_q   <= {r_q[30:0], 1'b0};
            end
        end
        if (i_cmd.upd) begin
            r_va[i_cmd.k] <= n_ua[31:0];
            r_vb[i_cmd.k] <= n_ub[31:0];
            r_ca <= r_ca | n_ua[32];
            r_cb <= r_cb | n_ub[32];
        end
        if (i_cmd.out_load) begin
            o_particle_index <= i_cmd.out_idx;
            o_out_vel_x      <= r_rdva[31:0];
            o_out_vel_y      <= r_rdva[63:32];
            o_out_vel_z      <= r_rdva[95:64];
            o_clipped        <= r_rdva[96];
            o_last_result    <= i_cmd.out_last;
        end
    end

    assign o_sts.skip = r_far || (r_s == '0) || r_s[33] || r_s[32];
endmodule
`default_nettype wire

// File: rtl/psrr_ctrl.sv
// Controller: load counter, pair sequencing, divider steps and result handshake.
`default_nettype none
module psrr_ctrl import psrr_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_last_particle,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  wire   i_out_stall,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CHK   = 4'd2;
    localparam logic [3:0] S_SQ    = 4'd3;
    localparam logic [3:0] S_SUM   = 4'd4;
    localparam logic [3:0] S_TST   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_DINI  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_UPD   = 4'd9;
    localparam logic [3:0] S_WRI   = 4'd10;
    localparam logic [3:0] S_WRJ   = 4'd11;
    localparam logic [3:0] S_NEXT  = 4'd12;
    localparam logic [3:0] S_ORD   = 4'd13;
    localparam logic [3:0] S_OLD   = 4'd14;
    localparam logic [3:0] S_OHOLD = 4'd15;

    logic [3:0]       r_st, n_st;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_o, n_o;
    logic [1:0]       r_k, n_k;
    logic [4:0]       r_bit, n_bit;
    logic             r_ovld, n_ovld;
    logic             n_acc;

    assign o_in_stall  = (r_st != S_IDLE);
    assign o_out_valid = r_ovld;
    assign n_acc       = i_in_valid && (r_st == S_IDLE);

    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_i    = r_i;
        n_j    = r_j;
        n_o    = r_o;
        n_k    = r_k;
        n_bit  = r_bit;
        n_ovld = r_ovld;
        o_cmd          = '0;
        o_cmd.rd_a     = r_i;
        o_cmd.rd_b     = r_j;
        o_cmd.k        = r_k;
        o_cmd.wr_addr  = r_cnt[IDX_W-1:0];
        o_cmd.wr_sel   = WSEL_LOAD;
        o_cmd.out_idx  = r_o;
        o_cmd.out_last = ({1'b0, r_o} == CNT_W'(r_cnt - 1'b1));
        unique case (r_st)
            S_IDLE: begin
                if (n_acc) begin
                    o_cmd.wr_en = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    if (i_last_particle || n_cnt == CNT_W'(MAX_P)) begin
                        n_i = IDX_W'(1);
                        n_j = '0;
                        n_o = '0;
                        n_st = (n_cnt == CNT_W'(1)) ? S_ORD : S_RD;
                    end
                end
            end
            S_RD:  n_st = S_CHK;
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_st = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_st = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_st = S_TST;
            end
            S_TST: begin
                n_k  = '0;
                n_st = i_sts.skip ? S_NEXT : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_st = S_DINI;
            end
            S_DINI: begin
                o_cmd.dinit = 1'b1;
                n_bit = '0;
                n_st = S_DIV;
            end
            S_DIV: begin
                o_cmd.dstep = 1'b1;
                n_bit = r_bit + 1'b1;
                if (r_bit == 5'd31)
                    n_st = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_k = r_k + 1'b1;
                n_st = (r_k == 2'd2) ? S_WRI : S_MUL;
            end
            S_WRI: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WSEL_A;
                o_cmd.wr_addr = r_i;
                n_st = S_WRJ;
            end
            S_WRJ: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = WSEL_B;
                o_cmd.wr_addr = r_j;
                n_st = S_NEXT;
            end
            S_NEXT: begin
                if (r_j + 1'b1 < r_i) begin
                    n_j  = r_j + 1'b1;
                    n_st = S_RD;
                end else if (CNT_W'(r_i) + 1'b1 < r_cnt) begin
                    n_i  = r_i + 1'b1;
                    n_j  = '0;
                    n_st = S_RD;
                end else begin
                    n_st = S_ORD;
                end
            end
            S_ORD: begin
                o_cmd.rd_a = r_o;
                n_st = S_OLD;
            end
            S_OLD: begin
                o_cmd.out_load = 1'b1;
                n_ovld = 1'b1;
                n_st = S_OHOLD;
            end
            S_OHOLD: begin
                // hold the result until the transfer completes
                if (!i_out_stall) begin
                    n_ovld = 1'b0;
                    if (o_cmd.out_last) begin
                        n_cnt = '0;
                        n_st  = S_IDLE;
                    end else begin
                        n_o  = r_o + 1'b1;
                        n_st = S_ORD;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
            r_i    <= '0;
            r_j    <= '0;
            r_o    <= '0;
            r_k    <= '0;
            r_bit  <= '0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_ovld <= n_ovld;
            r_i    <= n_i;
            r_j    <= n_j;
            r_o    <= n_o;
            r_k    <= n_k;
            r_bit  <= n_bit;
        end
    end

`ifndef SYNTHESIS
    a_vld_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_st == S_OHOLD)) else $error("result valid outside hold state");
    a_load_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_IDLE) |-> (r_cnt < CNT_W'(MAX_P))) else $error("load past capacity");
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_CHK) |-> (r_j < r_i && CNT_W'(r_i) < r_cnt))
        else $error("pair indices out of order");
`endif
endmodule
`default_nettype wire

// File: test/tb.sv
// Self-checking testbench for the pairwise short-range repulsion unit.
`timescale 1ns / 100ps
module tb;
    import psrr_pkg::*;

    typedef struct packed {
        bit [5:0]  idx;
        bit [31:0] vx, vy, vz;
        bit        clip, last;
    } t_vel_out;

    class vel_scoreboard;
        bit [31:0] gain = GAIN_RST;
        longint    pos[MAX_P][3];
        longint    vel[MAX_P][3];
        bit        clip[MAX_P];
        int        loaded;
        t_vel_out  pending[$];
        int        errors;

        function longint sat(longint v, longint f, int p);
            longint s;
            s = v + f;
            if (s > 64'sh7FFF_FFFF) begin
                clip[p] = 1;
                return 64'sh7FFF_FFFF;
            end
            if (s < -64'sh8000_0000) begin
                clip[p] = 1;
                return -64'sh8000_0000;
            end
            return s;
        endfunction

        function void repel(int a, int b);
            longint    d[3];
            longint    f;
            bit [63:0] s, mag, q;
            s = 0;
            for (int k = 0; k < 3; k++) begin
                d[k] = pos[a][k] - pos[b][k];
                if (d[k] >= 65536 || d[k] <= -65536) return;
            end
            for (int k = 0; k < 3; k++) s += d[k] * d[k];
            if (s == 0 || s >= 64'h1_0000_0000) return;
            for (int k = 0; k < 3; k++) begin
                mag = d[k] < 0 ? -d[k] : d[k];
                q = ((64'(gain) * mag) << 16) / s;
                if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
                f = d[k] < 0 ? -longint'(q) : longint'(q);
                vel[a][k] = sat(vel[a][k], f, a);
                vel[b][k] = sat(vel[b][k], -f, b);
            end
        endfunction

        function void note_input(bit [31:0] p[3], bit [31:0] v[3], bit last);
            t_vel_out e;
            for (int k = 0; k < 3; k++) begin
                pos[loaded][k] = longint'(signed'(p[k]));
                vel[loaded][k] = longint'(signed'(v[k]));
            end
            clip[loaded] = 0;
            loaded++;
            if (!last && loaded < MAX_P) return;
            for (int a = 0; a < loaded; a++)
                for (int b = 0; b < a; b++) repel(a, b);
            for (int a = 0; a < loaded; a++) begin
                e.idx  = a[5:0];
                e.vx   = vel[a][0][31:0];
                e.vy   = vel[a][1][31:0];
                e.vz   = vel[a][2][31:0];
                e.clip = clip[a];
                e.last = (a == loaded - 1);
                pending.push_back(e);
            end
            loaded = 0;
        endfunction

        function void check_result(t_vel_out got);
            t_vel_out e;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result for particle %0d", got.idx);
                return;
            end
            e = pending.pop_front();
            if (got != e) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: exp idx %0d v %h %h %h clip %b last %b",
                             e.idx, e.vx, e.vy, e.vz, e.clip, e.last);
                    $display("          got idx %0d v %h %h %h clip %b last %b",
                             got.idx, got.vx, got.vy, got.vz, got.clip, got.last);
                end
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 3000000;

    logic i_clk = 0, i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [31:0] i_cfg_wdata = 0;
    logic i_in_valid = 0, i_out_stall = 0, i_last_particle = 0;
    logic [31:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic [31:0] i_in_vel_x = 0, i_in_vel_y = 0, i_in_vel_z = 0;
    logic o_in_stall, o_out_valid, o_clipped, o_last_result;
    logic [IDX_W-1:0] o_particle_index;
    logic [31:0] o_out_vel_x, o_out_vel_y, o_out_vel_z;

    vel_scoreboard sb = new();
    bit quiet, hold_req, hold_done;
    int hold_left, burst_left, cycles, sent;

    pairwise_short_range_repulsion_unit uut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_vel_out got;
        if (o_out_valid && !i_out_stall) begin
            got.idx  = o_particle_index;
            got.vx   = o_out_vel_x;
            got.vy   = o_out_vel_y;
            got.vz   = o_out_vel_z;
            got.clip = o_clipped;
            got.last = o_last_result;
            sb.check_result(got);
        end
    end

    // Receiver back-pressure: random bursts, plus one long hold-off on request.
    // The hold-off outlasts the pair pass of a full set, so results back up behind it.
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done   <= 1;
            hold_left   <= 40000;
            i_out_stall <= 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) i_out_stall <= 0;
        end else if (quiet) begin
            i_out_stall <= 0;
        end else if (burst_left > 1) begin
            burst_left <= burst_left - 1;
        end else if (burst_left == 1) begin
            burst_left  <= 0;
            i_out_stall <= 0;
        end else if ($urandom_range(0, 9) == 0) begin
            burst_left  <= $urandom_range(1, 15);
            i_out_stall <= 1;
        end
    end

    task automatic send(bit [31:0] px, py, pz, vx, vy, vz, bit last);
        bit [31:0] p[3], v[3];
        int gap;
        p = '{px, py, pz};
        v = '{vx, vy, vz};
        i_in_valid      <= 1;
        i_pos_x         <= px;
        i_pos_y         <= py;
        i_pos_z         <= pz;
        i_in_vel_x      <= vx;
        i_in_vel_y      <= vy;
        i_in_vel_z      <= vz;
        i_last_particle <= last;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(p, v, last);
        sent++;
        gap = (quiet || $urandom_range(0, 5) != 0) ? 0 : $urandom_range(1, 15);
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off until every velocity is out and the block has settled, then write the gain.
    task automatic set_gain(bit [31:0] g);
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we    <= 1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.gain = g;
    endtask

    // A cluster of n particles around a random centre; spread bounds each offset.
    task automatic cluster(int n, int spread, bit end_set);
        bit [31:0] c[3], o[3];
        for (int k = 0; k < 3; k++) c[k] = $urandom;
        for (int i = 0; i < n; i++) begin
            for (int k = 0; k < 3; k++)
                o[k] = c[k] + $urandom_range(0, 2 * spread) - spread;
            if ($urandom_range(0, 1))
                send(o[0], o[1], o[2], $urandom, $urandom, $urandom,
                     end_set && i == n - 1);
            else
                send(o[0], o[1], o[2], $urandom_range(0, 4000) - 2000,
                     $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                     end_set && i == n - 1);
        end
    endtask

    initial begin
        bit [31:0] gains[5];
        gains = '{32'd0, GAIN_RST, 32'hFFFF_FFFF, 32'h0000_0400, 32'h0};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        set_gain(32'hFFFF_FFFF);

        // single particle at the field extremes
        send(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1);
        // coincident pair
        send(32'h0001_0000, 32'h2, 32'h3, 32'h5, 32'h6, 32'h7, 0);
        send(32'h0001_0000, 32'h2, 32'h3, 32'h8, 32'h9, 32'hA, 1);
        // distant pair, exactly 65536 apart in x, at the range limit
        send(32'h0, 32'h0, 32'h0, 32'h1, 32'h2, 32'h3, 0);
        send(32'h0001_0000, 32'h0, 32'h0, 32'h4, 32'h5, 32'h6, 1);
        // close pairs at the position extremes, driving velocities into saturation
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h7FFF_FFF0, 0);
        send(32'h7FFF_FFF0, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h8000_0010, 1);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 0);
        send(32'h8000_0001, 32'h8000_8000, 32'h8000_FFFF, 32'h1234_5678, 32'hEDCB_A987,
             32'h0, 0);
        send(32'h8000_4000, 32'h8000_2000, 32'h8000_1000, 32'hFFFF_FFFF, 32'h1, 32'h0, 1);
        set_gain(GAIN_RST);
        send(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 0);
        send(32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0080, 32'h0, 32'h0, 32'h0, 0);
        send(32'h0000_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1);

        // full set without a last marker, receiver held off while the next set queues
        set_gain($urandom);
        hold_req = 1;
        cluster(64, 32'h0004_0000, 0);
        cluster(3, 32'h0000_2000, 1);

        while (sent < 410) begin
            if (!quiet && $urandom_range(0, 7) == 0)
                set_gain(gains[$urandom_range(0, 4)] | ($urandom_range(0, 1) ? $urandom : 0));
            if (sent > 350) quiet = 1;
            cluster($urandom_range(1, 8),
                    $urandom_range(0, 3) == 0 ? 32'h0010_0000 : $urandom_range(0, 32'h6000),
                    1);
        end
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
